>>> src/avkf_pkg.sv
// ----------------------------------------------------------------------------
// avkf_pkg
// Shared types, codes and helpers of the altitude/velocity Kalman filter.
// ----------------------------------------------------------------------------
package avkf_pkg;

    localparam int DATA_W       = 32;
    localparam int CFG_W        = 31;
    localparam int CFG_IDX_W    = 8;
    localparam int FRAC_BITS_DEF = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_VAR = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_VAR  = 8'd1;

    typedef struct packed {
        logic        [DATA_W-1:0] sample_time;
        logic signed [DATA_W-1:0] measured_height;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] altitude_estimate;
        logic signed [DATA_W-1:0] climb_rate_estimate;
    } out_item_t;

    typedef enum logic [2:0] {
        ALU_ADD      = 3'd0,
        ALU_SUB      = 3'd1,
        ALU_MUL      = 3'd2,
        ALU_MUL_HALF = 3'd3,
        ALU_MUL_QTR  = 3'd4
    } alu_op_t;

    typedef struct packed {
        alu_op_t                  op;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic                     start;
        logic signed [DATA_W-1:0] num;
        logic signed [DATA_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] quot;
    } div_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CALC = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    // clip a wide signed value to the 32-bit signed range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> src/avkf_alu.sv
// ----------------------------------------------------------------------------
// avkf_alu
// Shared saturating add/subtract and fixed-point multiply unit.
// ----------------------------------------------------------------------------
module avkf_alu
    import avkf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  alu_req_t                 req,
    output logic signed [DATA_W-1:0] y
);

    logic signed [63:0]       prod;
    logic signed [63:0]       prod_sh;
    logic signed [63:0]       sum;
    logic signed [DATA_W-1:0] mul_sat;

    assign prod    = 64'(req.a) * 64'(req.b);
    // arithmetic shift floors toward minus infinity
    assign prod_sh = prod >>> FRAC_BITS;
    assign mul_sat = sat32(prod_sh);

    always_comb begin
        sum = 64'(req.a) + 64'(req.b);
        y   = '0;
        case (req.op)
            ALU_ADD:      y = sat32(sum);
            ALU_SUB: begin
                sum = 64'(req.a) - 64'(req.b);
                y   = sat32(sum);
            end
            ALU_MUL:      y = mul_sat;
            ALU_MUL_HALF: y = mul_sat >>> 1;
            ALU_MUL_QTR:  y = mul_sat >>> 2;
            default:      y = '0;
        endcase
    end

endmodule

>>> src/avkf_div.sv
// ----------------------------------------------------------------------------
// avkf_div
// Serial restoring divider: (num << FRAC_BITS) / den, truncated, saturated.
// ----------------------------------------------------------------------------
module avkf_div
    import avkf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int QW = DATA_W + FRAC_BITS;
    localparam int CW = $clog2(QW + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [QW-1:0]     nq_reg, nq_next;
    logic [DATA_W:0]   rem_reg, rem_next;
    logic [DATA_W-1:0] den_reg, den_next;
    logic              neg_reg, neg_next;
    logic              zero_reg, zero_next;

    logic [DATA_W-1:0] num_mag;
    logic [DATA_W-1:0] den_mag;
    logic [DATA_W:0]   shifted;
    logic              ge;

    assign num_mag = req.num[DATA_W-1] ? DATA_W'(-req.num) : DATA_W'(req.num);
    assign den_mag = req.den[DATA_W-1] ? DATA_W'(-req.den) : DATA_W'(req.den);
    assign shifted = {rem_reg[DATA_W-1:0], nq_reg[QW-1]};
    assign ge      = shifted >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        nq_next   = nq_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(QW);
            nq_next   = {num_mag, {FRAC_BITS{1'b0}}};
            rem_next  = '0;
            den_next  = den_mag;
            neg_next  = req.num[DATA_W-1] ^ req.den[DATA_W-1];
            zero_next = (req.den == '0);
        end else if (busy_reg) begin
            // one quotient bit per cycle
            rem_next = ge ? (shifted - {1'b0, den_reg}) : shifted;
            nq_next  = {nq_reg[QW-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        nq_reg   <= nq_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    // sign and clip the magnitude
    always_comb begin
        rsp.done = done_reg;
        if (zero_reg) begin
            rsp.quot = '0;
        end else if (neg_reg) begin
            if ((nq_reg[QW-1:DATA_W] != '0) ||
                (nq_reg[DATA_W-1] && (nq_reg[DATA_W-2:0] != '0))) begin
                rsp.quot = 32'sh8000_0000;
            end else begin
                rsp.quot = -$signed(nq_reg[DATA_W-1:0]);
            end
        end else if (nq_reg[QW-1:DATA_W-1] != '0) begin
            rsp.quot = 32'sh7FFF_FFFF;
        end else begin
            rsp.quot = $signed(nq_reg[DATA_W-1:0]);
        end
    end

endmodule

>>> src/altitude_velocity_kalman_filter.sv
// ----------------------------------------------------------------------------
// altitude_velocity_kalman_filter
// Two-state constant-velocity Kalman filter on barometric height samples.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s_        in         s_valid / s_ready      in_item_t  (time, height)
//  m_        out        m_valid / m_ready      out_item_t (altitude, climb rate)
//  cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One transaction takes 33 microcode steps of the shared ALU plus two serial
//  divisions; values are Q16.16 with the default FRAC_BITS.
//  The divider sets most of the time; the ALU does one op per cycle in S_CALC.
//  Reset (aresetn low, synchronous) restores state, covariance and configuration registers.
//  s_ready is high only while idle; a finished result waits in the output
//  register and a new transaction is taken as soon as the core is idle.
// ----------------------------------------------------------------------------
module altitude_velocity_kalman_filter
    import avkf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    localparam logic signed [DATA_W-1:0] ONE_FX = 32'sd1 <<< FRAC_BITS;
    localparam logic [CFG_W-1:0] ACCEL_VAR_RST = CFG_W'(64'd1 << FRAC_BITS);
    localparam logic [CFG_W-1:0] MEAS_VAR_RST  = CFG_W'((64'd8 << FRAC_BITS) / 64'd1000);

    // microcode steps, in execution order
    typedef enum logic [5:0] {
        U_T2, U_T3, U_T4, U_Q22, U_Q12, U_Q11,
        U_X0, U_PP12A, U_X1, U_PP11A, U_X2, U_PP11B, U_PP11C, U_PP12B,
        U_X3, U_PP21A, U_PP21B, U_PP22, U_X4, U_PS1, U_INN, U_IC,
        U_X5, U_ALT, U_X6, U_VEL, U_OM, U_CAA, U_CAV, U_X7, U_CVA, U_X8, U_CVV
    } step_t;

    typedef enum logic [4:0] {
        D_T2, D_T3, D_T4, D_Q22, D_Q12, D_Q11, D_X, D_PP11, D_PP12, D_PP21,
        D_PP22, D_PS1, D_INN, D_IC, D_ALT, D_VEL, D_OM, D_CAA, D_CAV, D_CVA, D_CVV
    } dest_t;

    state_t state_reg, state_next;
    step_t  step_reg;
    logic   div_sel_reg;
    logic   div_start_reg;

    logic [CFG_W-1:0] accel_var_reg, meas_var_reg;

    // filter state
    logic signed [DATA_W-1:0] alt_reg, vel_reg;
    logic        [DATA_W-1:0] prev_time_reg;
    logic signed [DATA_W-1:0] caa_reg, cav_reg, cva_reg, cvv_reg;

    // working registers of one transaction
    logic signed [DATA_W-1:0] t_reg, z_reg, t2_reg, t3_reg, t4_reg;
    logic signed [DATA_W-1:0] q11_reg, q12_reg, q22_reg, x_reg;
    logic signed [DATA_W-1:0] pp11_reg, pp12_reg, pp21_reg, pp22_reg;
    logic signed [DATA_W-1:0] ps1_reg, inn_reg, ic_reg, kg1_reg, kg2_reg, om_reg;

    logic      m_valid_reg;
    out_item_t m_data_reg;

    alu_req_t                 alu_req;
    logic signed [DATA_W-1:0] alu_y;
    dest_t                    dest;
    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    logic        [DATA_W-1:0] dt;
    logic signed [DATA_W-1:0] var_s, rv_s;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign var_s     = $signed({1'b0, accel_var_reg});
    assign rv_s      = $signed({1'b0, meas_var_reg});

    // interval: clamp backward time to zero, long interval to the top value
    assign dt = (s_data.sample_time >= prev_time_reg) ?
                (s_data.sample_time - prev_time_reg) : '0;

    avkf_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
        .req (alu_req),
        .y   (alu_y)
    );

    assign div_req.start = div_start_reg;
    assign div_req.num   = div_sel_reg ? pp21_reg : pp11_reg;
    assign div_req.den   = ic_reg;

    avkf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // microcode: operands, op and destination for each step
    always_comb begin
        alu_req.op = ALU_MUL;
        alu_req.a  = t_reg;
        alu_req.b  = t_reg;
        dest       = D_X;
        case (step_reg)
            U_T2:    begin alu_req.a = t_reg;  alu_req.b = t_reg;  dest = D_T2; end
            U_T3:    begin alu_req.a = t2_reg; alu_req.b = t_reg;  dest = D_T3; end
            U_T4:    begin alu_req.a = t3_reg; alu_req.b = t_reg;  dest = D_T4; end
            U_Q22:   begin alu_req.a = var_s;  alu_req.b = t2_reg; dest = D_Q22; end
            U_Q12: begin
                alu_req.op = ALU_MUL_HALF; alu_req.a = var_s; alu_req.b = t3_reg;
                dest = D_Q12;
            end
            U_Q11: begin
                alu_req.op = ALU_MUL_QTR; alu_req.a = var_s; alu_req.b = t4_reg;
                dest = D_Q11;
            end
            U_X0:    begin alu_req.b = cvv_reg; end
            U_PP12A: begin
                alu_req.op = ALU_ADD; alu_req.a = cav_reg; alu_req.b = x_reg;
                dest = D_PP12;
            end
            U_X1:    begin alu_req.b = cva_reg; end
            U_PP11A: begin
                alu_req.op = ALU_ADD; alu_req.a = caa_reg; alu_req.b = x_reg;
                dest = D_PP11;
            end
            U_X2:    begin alu_req.b = pp12_reg; end
            U_PP11B: begin
                alu_req.op = ALU_ADD; alu_req.a = pp11_reg; alu_req.b = x_reg;
                dest = D_PP11;
            end
            U_PP11C: begin
                alu_req.op = ALU_ADD; alu_req.a = pp11_reg; alu_req.b = q11_reg;
                dest = D_PP11;
            end
            U_PP12B: begin
                alu_req.op = ALU_ADD; alu_req.a = pp12_reg; alu_req.b = q12_reg;
                dest = D_PP12;
            end
            U_X3:    begin alu_req.b = cvv_reg; end
            U_PP21A: begin
                alu_req.op = ALU_ADD; alu_req.a = cva_reg; alu_req.b = x_reg;
                dest = D_PP21;
            end
            U_PP21B: begin
                alu_req.op = ALU_ADD; alu_req.a = pp21_reg; alu_req.b = q12_reg;
                dest = D_PP21;
            end
            U_PP22: begin
                alu_req.op = ALU_ADD; alu_req.a = cvv_reg; alu_req.b = q22_reg;
                dest = D_PP22;
            end
            U_X4:    begin alu_req.b = vel_reg; end
            U_PS1: begin
                alu_req.op = ALU_ADD; alu_req.a = alt_reg; alu_req.b = x_reg;
                dest = D_PS1;
            end
            U_INN: begin
                alu_req.op = ALU_SUB; alu_req.a = z_reg; alu_req.b = ps1_reg;
                dest = D_INN;
            end
            U_IC: begin
                alu_req.op = ALU_ADD; alu_req.a = pp11_reg; alu_req.b = rv_s;
                dest = D_IC;
            end
            U_X5:    begin alu_req.a = kg1_reg; alu_req.b = inn_reg; end
            U_ALT: begin
                alu_req.op = ALU_ADD; alu_req.a = ps1_reg; alu_req.b = x_reg;
                dest = D_ALT;
            end
            U_X6:    begin alu_req.a = kg2_reg; alu_req.b = inn_reg; end
            U_VEL: begin
                alu_req.op = ALU_ADD; alu_req.a = vel_reg; alu_req.b = x_reg;
                dest = D_VEL;
            end
            U_OM: begin
                alu_req.op = ALU_SUB; alu_req.a = ONE_FX; alu_req.b = kg1_reg;
                dest = D_OM;
            end
            U_CAA:   begin alu_req.a = pp11_reg; alu_req.b = om_reg; dest = D_CAA; end
            U_CAV:   begin alu_req.a = pp12_reg; alu_req.b = om_reg; dest = D_CAV; end
            U_X7:    begin alu_req.a = pp11_reg; alu_req.b = kg2_reg; end
            U_CVA: begin
                alu_req.op = ALU_SUB; alu_req.a = pp21_reg; alu_req.b = x_reg;
                dest = D_CVA;
            end
            U_X8:    begin alu_req.a = pp12_reg; alu_req.b = kg2_reg; end
            U_CVV: begin
                alu_req.op = ALU_SUB; alu_req.a = pp22_reg; alu_req.b = x_reg;
                dest = D_CVV;
            end
            default: begin end
        endcase
    end

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_valid) state_next = S_CALC;
            S_CALC: begin
                if (step_reg == U_IC) begin
                    state_next = S_DIV;
                end else if (step_reg == U_CVV) begin
                    state_next = S_DONE;
                end
            end
            S_DIV:  if (div_rsp.done && div_sel_reg) state_next = S_CALC;
            S_DONE: if (!m_valid_reg || m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            step_reg      <= U_T2;
            div_sel_reg   <= 1'b0;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            accel_var_reg <= ACCEL_VAR_RST;
            meas_var_reg  <= MEAS_VAR_RST;
            alt_reg       <= '0;
            vel_reg       <= '0;
            prev_time_reg <= '0;
            caa_reg       <= ONE_FX;
            cav_reg       <= '0;
            cva_reg       <= '0;
            cvv_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            div_start_reg <= 1'b0;

            if (cfg_valid) begin
                case (cfg_index)
                    CFG_ACCEL_VAR: accel_var_reg <= cfg_data[CFG_W-1:0];
                    CFG_MEAS_VAR:  meas_var_reg  <= cfg_data[CFG_W-1:0];
                    default: begin end
                endcase
            end

            // present a finished result, or drop the one just taken
            if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    // take the transaction and latch the interval
                    if (s_valid) begin
                        step_reg      <= U_T2;
                        prev_time_reg <= s_data.sample_time;
                        t_reg         <= dt[DATA_W-1] ? 32'sh7FFF_FFFF : $signed(dt);
                        z_reg         <= s_data.measured_height;
                    end
                end
                S_CALC: begin
                    case (dest)
                        D_ALT: alt_reg <= alu_y;
                        D_VEL: vel_reg <= alu_y;
                        D_CAA: caa_reg <= alu_y;
                        D_CAV: cav_reg <= alu_y;
                        D_CVA: cva_reg <= alu_y;
                        D_CVV: cvv_reg <= alu_y;
                        default: begin end
                    endcase
                    if (step_reg == U_IC) begin
                        div_sel_reg   <= 1'b0;
                        div_start_reg <= 1'b1;
                    end else if (step_reg != U_CVV) begin
                        step_reg <= step_t'(step_reg + 6'd1);
                    end
                end
                S_DIV: begin
                    // gains: first pp11 / ic, then pp21 / ic
                    if (div_rsp.done) begin
                        if (!div_sel_reg) begin
                            div_sel_reg   <= 1'b1;
                            div_start_reg <= 1'b1;
                        end else begin
                            step_reg <= U_X5;
                        end
                    end
                end
                S_DONE: begin
                    // the output register is loaded outside this case
                end
                default: begin end
            endcase
        end
    end

    // working registers and output payload
    always_ff @(posedge aclk) begin
        if (state_reg == S_CALC) begin
            case (dest)
                D_T2:   t2_reg   <= alu_y;
                D_T3:   t3_reg   <= alu_y;
                D_T4:   t4_reg   <= alu_y;
                D_Q22:  q22_reg  <= alu_y;
                D_Q12:  q12_reg  <= alu_y;
                D_Q11:  q11_reg  <= alu_y;
                D_X:    x_reg    <= alu_y;
                D_PP11: pp11_reg <= alu_y;
                D_PP12: pp12_reg <= alu_y;
                D_PP21: pp21_reg <= alu_y;
                D_PP22: pp22_reg <= alu_y;
                D_PS1:  ps1_reg  <= alu_y;
                D_INN:  inn_reg  <= alu_y;
                D_IC:   ic_reg   <= alu_y;
                D_OM:   om_reg   <= alu_y;
                default: begin end
            endcase
        end
        if (state_reg == S_DIV && div_rsp.done) begin
            if (div_sel_reg) begin
                kg2_reg <= div_rsp.quot;
            end else begin
                kg1_reg <= div_rsp.quot;
            end
        end
        if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
            m_data_reg.altitude_estimate   <= alt_reg;
            m_data_reg.climb_rate_estimate <= vel_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_CALC && step_reg == U_T2))
        else $error("accepted transaction did not start the microcode");

    a_div_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start_reg |-> (state_reg == S_DIV))
        else $error("divider started outside the divide phase");

    a_done_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && (!m_valid_reg || m_ready)) |=>
        (m_valid && m_data.altitude_estimate == $past(alt_reg)))
        else $error("finished result not presented");
`endif

endmodule
